[sv/vefc_pkg.sv]
`default_nettype none
package vefc_pkg;

  localparam int unsigned HDR_LEN     = 30;
  localparam int unsigned WIN_LEN     = 8;
  localparam int unsigned ADDR_NUM    = 4;
  localparam int unsigned ADDR_BYTES  = 6;
  localparam int unsigned PAT_BYTES   = 5;
  localparam int unsigned PAT_W       = 8 * PAT_BYTES;
  localparam int unsigned ADDR_W      = 8 * ADDR_BYTES;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned HDR_IDX_W   = $clog2(HDR_LEN);

  localparam logic [POS_W-1:0] MAX_FRAME_LEN = 16'd65535;
  localparam logic [POS_W-1:0] WIN_FULL_POS  = 16'd7;
  localparam logic [POS_W-1:0] HDR_LEN_POS   = 16'd30;

  localparam logic [7:0] ELEMENT_ID   = 8'hdd;
  localparam logic [7:0] TYPE_STATION = 8'h01;
  localparam logic [7:0] TYPE_VEHICLE = 8'h02;

  localparam logic [PAT_W-1:0] PATTERN_RESET = 40'h70b3d53190;

  localparam int unsigned ADDR_OFF [ADDR_NUM] = '{4, 10, 16, 24};
  localparam int unsigned ADDR2_SEL = 1;
  localparam int unsigned ADDR3_SEL = 2;

  typedef logic [7:0]        byte_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    CLASS_NONE    = 2'd0,
    CLASS_STATION = 2'd1,
    CLASS_VEHICLE = 2'd2,
    CLASS_KNOWN   = 2'd3
  } class_e;

  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctrl_t;

  typedef struct packed {
    logic  care;
    byte_t value;
  } cell_ref_t;

  typedef struct packed {
    logic                 wr;
    logic                 clr;
    logic [HDR_IDX_W-1:0] idx;
    byte_t                data;
  } hdr_ctrl_t;

endpackage
`default_nettype wire

[sv/vefc_if.sv]
`default_nettype none
interface vefc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface vefc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  class_code;
  logic [47:0] station_address;
  logic [47:0] vehicle_address;

  modport source (output valid, output class_code, output station_address,
                  output vehicle_address, input ready);
  modport sink   (input valid, input class_code, input station_address,
                  input vehicle_address, output ready);
endinterface

interface vefc_cfg_if;
  logic        valid;
  logic        ready;
  logic [39:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/vefc_cell.sv]
`default_nettype none
module vefc_cell (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire vefc_pkg::cell_ctrl_t  ctrl_i,
  input  wire vefc_pkg::byte_t       data_i,
  input  wire vefc_pkg::cell_ref_t   ref_i,
  output vefc_pkg::byte_t            data_o,
  output logic                       hit_o
);
  import vefc_pkg::*;

  byte_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.clr) begin
      data_d = '0;
    end else if (ctrl_i.shift) begin
      data_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;
  assign hit_o  = !ref_i.care || (data_i == ref_i.value);

endmodule
`default_nettype wire

[sv/vefc_hdr.sv]
`default_nettype none
module vefc_hdr (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire vefc_pkg::hdr_ctrl_t  ctrl_i,
  output vefc_pkg::addr_t           addr_o [vefc_pkg::ADDR_NUM]
);
  import vefc_pkg::*;

  byte_t hdr_q [HDR_LEN];
  byte_t hdr_n [HDR_LEN];

  always_comb begin
    for (int i = 0; i < HDR_LEN; i++) begin
      hdr_n[i] = (ctrl_i.wr && (ctrl_i.idx == HDR_IDX_W'(i))) ? ctrl_i.data : hdr_q[i];
    end
  end

  always_comb begin
    for (int a = 0; a < ADDR_NUM; a++) begin
      for (int k = 0; k < ADDR_BYTES; k++) begin
        addr_o[a][8*(ADDR_BYTES-1-k) +: 8] = hdr_n[ADDR_OFF[a] + k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HDR_LEN; i++) begin
        hdr_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < HDR_LEN; i++) begin
        hdr_q[i] <= ctrl_i.clr ? 8'h00 : hdr_n[i];
      end
    end
  end

endmodule
`default_nettype wire

[sv/vendor_element_frame_classifier_unit.sv]
// Vendor element frame classifier.
// in_i carries one frame byte per beat with last_byte on the final byte;
// out_o carries one beat per frame: class_code plus the learned station and
// vehicle addresses after that frame. cfg_i writes the 40-bit vendor
// pattern and is always ready; write it only while no frame is in flight.
// A row of eight byte cells holds the scan window and shifts once per
// accepted byte among the first 65535 of a frame; cell 0 checks its
// incoming byte against the element ID and cells 2..6 against their slot
// of the pattern, combinationally. Header bytes 0..29 sit in a separate
// store that feeds four address compares. Throughput: one byte per cycle
// while in_i.ready is high. The result beat is valid in the cycle after
// the last byte is accepted, from an output register. in_i.ready drops
// only while a result beat waits and out_o.ready is low; the input then
// stalls until the beat is taken. Reset clears the window, header store,
// position, learned addresses and restores the default vendor pattern.
`default_nettype none
module vendor_element_frame_classifier_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vefc_in_if.sink    in_i,
  vefc_out_if.source out_o,
  vefc_cfg_if.sink   cfg_i
);
  import vefc_pkg::*;

  logic [PAT_W-1:0] pattern_q;
  logic [POS_W-1:0] pos_q, pos_d;
  class_e           fm_q, fm_d;
  addr_t            station_q, station_d;
  addr_t            vehicle_q, vehicle_d;
  logic             out_vq;
  class_e           out_class_q, class_d;
  addr_t            out_station_q, out_vehicle_q;

  logic       in_acc, shift, frame_end;
  cell_ctrl_t cell_ctrl;
  hdr_ctrl_t  hdr_ctrl;
  byte_t      win_q   [WIN_LEN];
  byte_t      cell_in [WIN_LEN];
  cell_ref_t  cell_ref [WIN_LEN];
  logic [WIN_LEN-1:0] cell_hit;
  addr_t      hdr_addr [ADDR_NUM];
  class_e     win_code;
  logic       known;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_vq || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign shift       = in_acc && (pos_q != MAX_FRAME_LEN);
  assign frame_end   = in_acc && in_i.last_byte;

  assign cell_ctrl.shift = shift;
  assign cell_ctrl.clr   = frame_end;

  always_comb begin
    for (int k = 0; k < WIN_LEN; k++) begin
      cell_in[k]  = (k == WIN_LEN - 1) ? in_i.frame_byte : win_q[(k + 1) % WIN_LEN];
      cell_ref[k] = '{care: 1'b0, value: 8'h00};
      if (k == 0) begin
        cell_ref[k] = '{care: 1'b1, value: ELEMENT_ID};
      end else if (k >= 2 && k < 2 + PAT_BYTES) begin
        cell_ref[k] = '{care: 1'b1, value: pattern_q[8*(PAT_BYTES+1-k) +: 8]};
      end
    end
  end

  for (genvar g = 0; g < WIN_LEN; g++) begin : g_cell
    vefc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .data_i (cell_in[g]),
      .ref_i  (cell_ref[g]),
      .data_o (win_q[g]),
      .hit_o  (cell_hit[g])
    );
  end

  assign hdr_ctrl.wr   = shift && (pos_q < HDR_LEN_POS);
  assign hdr_ctrl.clr  = frame_end;
  assign hdr_ctrl.idx  = pos_q[HDR_IDX_W-1:0];
  assign hdr_ctrl.data = in_i.frame_byte;

  vefc_hdr u_hdr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (hdr_ctrl),
    .addr_o (hdr_addr)
  );

  always_comb begin
    win_code = CLASS_NONE;
    if (&cell_hit) begin
      if (in_i.frame_byte == TYPE_STATION) begin
        win_code = CLASS_STATION;
      end else if (in_i.frame_byte == TYPE_VEHICLE) begin
        win_code = CLASS_VEHICLE;
      end
    end
  end

  always_comb begin
    known = 1'b0;
    for (int a = 0; a < ADDR_NUM; a++) begin
      if (hdr_addr[a] == station_q || hdr_addr[a] == vehicle_q) begin
        known = 1'b1;
      end
    end
  end

  always_comb begin
    fm_d      = fm_q;
    pos_d     = pos_q;
    station_d = station_q;
    vehicle_d = vehicle_q;
    class_d   = CLASS_NONE;
    if (shift) begin
      pos_d = pos_q + 16'd1;
      if (pos_q >= WIN_FULL_POS && fm_q == CLASS_NONE) begin
        fm_d = win_code;
      end
    end
    case (fm_d)
      CLASS_STATION: begin
        class_d   = CLASS_STATION;
        station_d = hdr_addr[ADDR3_SEL];
      end
      CLASS_VEHICLE: begin
        class_d   = CLASS_VEHICLE;
        vehicle_d = hdr_addr[ADDR2_SEL];
      end
      default: begin
        class_d = known ? CLASS_KNOWN : CLASS_NONE;
      end
    endcase
    if (frame_end) begin
      fm_d  = CLASS_NONE;
      pos_d = '0;
    end else begin
      station_d = station_q;
      vehicle_d = vehicle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= PATTERN_RESET;
      pos_q     <= '0;
      fm_q      <= CLASS_NONE;
      station_q <= '0;
      vehicle_q <= '0;
      out_vq    <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        pattern_q <= cfg_i.data;
      end
      pos_q     <= pos_d;
      fm_q      <= fm_d;
      station_q <= station_d;
      vehicle_q <= vehicle_d;
      if (frame_end) begin
        out_vq <= 1'b1;
      end else if (out_o.ready) begin
        out_vq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      out_class_q   <= class_d;
      out_station_q <= station_d;
      out_vehicle_q <= vehicle_d;
    end
  end

  assign out_o.valid           = out_vq;
  assign out_o.class_code      = out_class_q;
  assign out_o.station_address = out_station_q;
  assign out_o.vehicle_address = out_vehicle_q;

endmodule
`default_nettype wire

[tb/vendor_element_frame_classifier_unit_tb.sv]
module vendor_element_frame_classifier_unit_tb;
  import vefc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned PHASE_BYTES = 450;

  typedef struct {
    class_e code;
    addr_t  station;
    addr_t  vehicle;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  vefc_in_if  in_i();
  vefc_out_if out_o();
  vefc_cfg_if cfg_i();

  vendor_element_frame_classifier_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i)
  );

  logic [PAT_W-1:0] vendor_pat;
  byte_t            scan_win [WIN_LEN];
  byte_t            hdr_bytes [HDR_LEN];
  int unsigned      frame_pos;
  class_e           elem_hit;
  addr_t            station_mac;
  addr_t            vehicle_mac;
  verdict_t         verdict_q [$];
  verdict_t         seen;
  int unsigned      idle_pct;
  int unsigned      stall_pct;
  int unsigned      errors;
  int unsigned      quiet_cycles;

  function automatic void clear_frame();
    foreach (scan_win[k]) scan_win[k] = '0;
    foreach (hdr_bytes[k]) hdr_bytes[k] = '0;
    frame_pos = 0;
    elem_hit  = CLASS_NONE;
  endfunction

  function automatic addr_t header_addr(input int unsigned off);
    addr_t a;
    a = '0;
    for (int k = 0; k < ADDR_BYTES; k++) a = {a[ADDR_W-9:0], hdr_bytes[off + k]};
    return a;
  endfunction

  function automatic class_e element_type();
    if (scan_win[0] != ELEMENT_ID) return CLASS_NONE;
    for (int k = 0; k < PAT_BYTES; k++)
      if (scan_win[2 + k] != vendor_pat[8 * (PAT_BYTES - 1 - k) +: 8]) return CLASS_NONE;
    if (scan_win[WIN_LEN-1] == TYPE_STATION) return CLASS_STATION;
    if (scan_win[WIN_LEN-1] == TYPE_VEHICLE) return CLASS_VEHICLE;
    return CLASS_NONE;
  endfunction

  function automatic void classify_byte(input byte_t b, input logic last);
    verdict_t v;
    if (frame_pos < MAX_FRAME_LEN) begin
      for (int k = 0; k < WIN_LEN - 1; k++) scan_win[k] = scan_win[k + 1];
      scan_win[WIN_LEN-1] = b;
      if (frame_pos < HDR_LEN) hdr_bytes[frame_pos] = b;
      if (frame_pos >= WIN_LEN - 1 && elem_hit == CLASS_NONE) elem_hit = element_type();
      frame_pos++;
    end
    if (last) begin
      v.code = CLASS_NONE;
      if (elem_hit == CLASS_STATION) begin
        station_mac = header_addr(ADDR_OFF[ADDR3_SEL]);
        v.code = CLASS_STATION;
      end else if (elem_hit == CLASS_VEHICLE) begin
        vehicle_mac = header_addr(ADDR_OFF[ADDR2_SEL]);
        v.code = CLASS_VEHICLE;
      end else begin
        for (int k = 0; k < ADDR_NUM; k++)
          if (header_addr(ADDR_OFF[k]) == station_mac || header_addr(ADDR_OFF[k]) == vehicle_mac)
            v.code = CLASS_KNOWN;
      end
      v.station = station_mac;
      v.vehicle = vehicle_mac;
      verdict_q.push_back(v);
      clear_frame();
    end
  endfunction

  function automatic byte_t elem_byte(input int unsigned k, input byte_t kind);
    case (k)
      0: return ELEMENT_ID;
      1: return byte_t'($urandom_range(255));
      WIN_LEN - 1: return kind;
      default: return vendor_pat[8 * (PAT_BYTES + 1 - k) +: 8];
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) out_o.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_o.valid && out_o.ready) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual class %0d station %h vehicle %h",
                   $time, out_o.class_code, out_o.station_address, out_o.vehicle_address);
        end else begin
          seen = verdict_q.pop_front();
          if (out_o.class_code !== seen.code) begin
            errors++;
            $display("%0t: class_code mismatch, expected %0d actual %0d",
                     $time, seen.code, out_o.class_code);
          end
          if (out_o.station_address !== seen.station) begin
            errors++;
            $display("%0t: station_address mismatch, expected %h actual %h",
                     $time, seen.station, out_o.station_address);
          end
          if (out_o.vehicle_address !== seen.vehicle) begin
            errors++;
            $display("%0t: vehicle_address mismatch, expected %h actual %h",
                     $time, seen.vehicle, out_o.vehicle_address);
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) vendor_pat = cfg_i.data;
      if (in_i.valid && in_i.ready) classify_byte(in_i.frame_byte, in_i.last_byte);
      if ((in_i.valid && in_i.ready) || (out_o.valid && out_o.ready) ||
          (cfg_i.valid && cfg_i.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_beat(input byte_t b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_i.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_i.valid      <= 1'b1;
    in_i.frame_byte <= b;
    in_i.last_byte  <= last;
    do @(posedge clk_i); while (!in_i.ready);
  endtask

  task automatic send_frame(input byte_t fr[$]);
    foreach (fr[i]) send_beat(fr[i], i == fr.size() - 1);
  endtask

  task automatic drain_results();
    in_i.valid <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_pattern(input logic [PAT_W-1:0] pat);
    cfg_i.valid <= 1'b1;
    cfg_i.data  <= pat;
    do @(posedge clk_i); while (!cfg_i.ready);
    cfg_i.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_frame(output byte_t fr[$]);
    int unsigned len;
    int unsigned pick;
    int unsigned at;
    int unsigned n_elem;
    int unsigned bad;
    addr_t       a;
    byte_t       kind;
    fr = {};
    pick = $urandom_range(99);
    if (pick < 15) len = $urandom_range(23, 1);
    else if (pick < 85) len = $urandom_range(60, 24);
    else if (pick < 97) len = $urandom_range(160, 61);
    else len = $urandom_range(400, 161);
    repeat (len)
      fr.push_back(($urandom_range(15) == 0) ? ELEMENT_ID : byte_t'($urandom_range(255)));
    for (int i = 0; i < ADDR_NUM; i++) begin
      pick = $urandom_range(7);
      a = (pick == 0) ? station_mac : (pick == 1) ? vehicle_mac :
          (pick == 2) ? addr_t'(0) : {16'($urandom), $urandom};
      for (int k = 0; k < ADDR_BYTES; k++)
        if (ADDR_OFF[i] + k < len) fr[ADDR_OFF[i] + k] = a[8 * (ADDR_BYTES - 1 - k) +: 8];
    end
    n_elem = ($urandom_range(9) < 7) ? $urandom_range(2, 1) : 0;
    repeat (n_elem) begin
      pick = $urandom_range(99);
      kind = (pick < 45) ? TYPE_STATION : (pick < 90) ? TYPE_VEHICLE :
             byte_t'($urandom_range(255));
      if (len >= WIN_LEN && $urandom_range(7) != 0) at = $urandom_range(len - WIN_LEN, 0);
      else at = $urandom_range(len - 1, 0);
      for (int k = 0; k < WIN_LEN; k++)
        if (at + k < len) fr[at + k] = elem_byte(k, kind);
      bad = $urandom_range(6, 2);
      if ($urandom_range(7) == 0 && at + bad < len)
        fr[at + bad] = fr[at + bad] ^ byte_t'(1 << $urandom_range(7));
    end
  endtask

  task automatic test_element_cases();
    byte_t fr[$];
    idle_pct  = 0;
    stall_pct = 0;
    fr = {8'hff};
    send_frame(fr);
    fr = {};
    for (int k = 0; k < WIN_LEN; k++) fr.push_back(elem_byte(k, TYPE_STATION));
    fr[1] = 8'h00;
    send_frame(fr);
    fr = {};
    for (int k = 0; k < WIN_LEN; k++) fr.push_back(elem_byte(k, TYPE_VEHICLE));
    fr[1] = 8'hff;
    send_frame(fr);
    fr = {};
    for (int k = 0; k < WIN_LEN; k++) fr.push_back(elem_byte(k, 8'h00));
    fr.push_back(ELEMENT_ID);
    fr.push_back(8'h00);
    send_frame(fr);
    drain_results();
  endtask

  task automatic test_traffic(input int unsigned idle, input int unsigned stall,
                              input logic [PAT_W-1:0] pat);
    byte_t       fr[$];
    int unsigned sent;
    drain_results();
    write_pattern(pat);
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < PHASE_BYTES) begin
      random_frame(fr);
      send_frame(fr);
      sent += fr.size();
      if ($urandom_range(19) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_i.valid      = 1'b0;
    in_i.frame_byte = '0;
    in_i.last_byte  = 1'b0;
    cfg_i.valid     = 1'b0;
    cfg_i.data      = '0;
    out_o.ready     = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    errors          = 0;
    quiet_cycles    = 0;
    vendor_pat      = PATTERN_RESET;
    station_mac     = '0;
    vehicle_mac     = '0;
    clear_frame();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_element_cases();
    test_traffic(0, 0, '0);
    test_traffic(83, 0, '1);
    test_traffic(0, 83, {8'($urandom), $urandom});
    test_traffic(21, 21, PATTERN_RESET);
    drain_results();
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
